[design/pra_pkg.sv]
// Shared types and constants for the proximity risk alert block.
// No dependencies; every other file of the block imports this package.
package pra_pkg;

    // Fixed field widths.
    localparam int DIST_BITS_DEF = 10;
    localparam int SPEED_BITS    = 10;
    localparam int BLINK_BITS    = 16;
    localparam int TIME_BITS     = 32;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int MS_PER_S      = 1000;
    localparam int MS_PER_S_BITS = 10;

    // Register reset values.
    localparam int CRIT_NEAR_RESET   = 10;
    localparam int CRIT_FAST_RESET   = 20;
    localparam int HIGH_NEAR_RESET   = 25;
    localparam int HIGH_MOD_RESET    = 30;
    localparam int WARNING_RESET     = 40;
    localparam int FAST_SPEED_RESET  = 10;
    localparam int MOD_SPEED_RESET   = 5;
    localparam int BLINK_RESET       = 200;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CRIT_NEAR  = 4'd0,
        REG_CRIT_FAST  = 4'd1,
        REG_HIGH_NEAR  = 4'd2,
        REG_HIGH_MOD   = 4'd3,
        REG_WARNING    = 4'd4,
        REG_FAST_SPEED = 4'd5,
        REG_MOD_SPEED  = 4'd6,
        REG_BLINK      = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RISK_SAFE     = 2'd0,
        RISK_WARNING  = 2'd1,
        RISK_HIGH     = 2'd2,
        RISK_CRITICAL = 2'd3
    } risk_t;

    // Closing speed flags, as seen by the per-side risk grading.
    typedef struct packed {
        logic fast;
        logic moderate;
    } closing_t;

endpackage

[design/proximity_risk_alert.sv]
// Top level of the proximity risk alert block: input register, round
// evaluation, state update and result register. Depends on pra_pkg and pra_side_risk.
//
// One item is one measurement round; the block accepts one every clock cycle
// as long as the result side keeps taking items. A round that is accepted is
// held in the input register, moves on to the result register and is
// presented on the result side from there until it is taken. The
// closing speed test, the side grading and the LED blink decision for a round
// all complete in the cycle in which the round moves from the input
// register to the result register, which is also the cycle in which the
// stored nearest distance, timestamp, flags and blink state are updated, so
// each round sees the state left by the round before it. The configuration
// port is always ready; registers may only be written while no round is in
// flight.
module proximity_risk_alert #(
    parameter int DIST_BITS = pra_pkg::DIST_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pra_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pra_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: dist_left_cm, dist_right_cm, dist_back_cm, now_ms, zero pad
    input  logic [((3*DIST_BITS+pra_pkg::TIME_BITS+7)/8)*8-1:0] s_tdata,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: risk_left, risk_right, risk_back, alert_level,
    // nearest_cm, show_mask, compact_labels, buzzer_pattern, led_on, zero pad
    output logic [((DIST_BITS+15+7)/8)*8-1:0]   m_tdata
);
    import pra_pkg::*;

    localparam int OUT_BITS   = DIST_BITS + 15;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
    localparam int CLOSE_BITS = DIST_BITS + MS_PER_S_BITS;
    localparam int PROD_BITS  = SPEED_BITS + TIME_BITS;

    // Configuration registers.
    logic [DIST_BITS-1:0]  crit_near_reg, crit_fast_reg, high_near_reg;
    logic [DIST_BITS-1:0]  high_mod_reg, warning_reg;
    logic [SPEED_BITS-1:0] fast_speed_reg, mod_speed_reg;
    logic [BLINK_BITS-1:0] blink_period_reg;

    // Round state.
    logic [DIST_BITS-1:0]  last_nearest_reg;
    logic [TIME_BITS-1:0]  last_time_reg, last_toggle_reg;
    closing_t              closing_reg;
    logic                  blink_phase_reg, led_level_reg;

    // Input register.
    logic                  in_valid_reg;
    logic [DIST_BITS-1:0]  dl_reg, dr_reg, db_reg;
    logic [TIME_BITS-1:0]  now_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                  advance;
    logic [DIST_BITS-1:0]  nearest;
    logic [TIME_BITS-1:0]  dt, since_toggle;
    logic                  approaching;
    logic [CLOSE_BITS-1:0] closing_num;
    logic [PROD_BITS-1:0]  fast_rhs, mod_rhs;
    closing_t              closing_next;
    risk_t                 rl, rr, rb, lvl, th;
    logic [2:0]            mask;
    logic                  compact;
    logic                  blink_phase_next, led_level_next;
    logic [TIME_BITS-1:0]  last_toggle_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_W'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_near_reg    <= DIST_BITS'(CRIT_NEAR_RESET);
            crit_fast_reg    <= DIST_BITS'(CRIT_FAST_RESET);
            high_near_reg    <= DIST_BITS'(HIGH_NEAR_RESET);
            high_mod_reg     <= DIST_BITS'(HIGH_MOD_RESET);
            warning_reg      <= DIST_BITS'(WARNING_RESET);
            fast_speed_reg   <= SPEED_BITS'(FAST_SPEED_RESET);
            mod_speed_reg    <= SPEED_BITS'(MOD_SPEED_RESET);
            blink_period_reg <= BLINK_BITS'(BLINK_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CRIT_NEAR:  crit_near_reg    <= cfg_data[DIST_BITS-1:0];
                REG_CRIT_FAST:  crit_fast_reg    <= cfg_data[DIST_BITS-1:0];
                REG_HIGH_NEAR:  high_near_reg    <= cfg_data[DIST_BITS-1:0];
                REG_HIGH_MOD:   high_mod_reg     <= cfg_data[DIST_BITS-1:0];
                REG_WARNING:    warning_reg      <= cfg_data[DIST_BITS-1:0];
                REG_FAST_SPEED: fast_speed_reg   <= cfg_data[SPEED_BITS-1:0];
                REG_MOD_SPEED:  mod_speed_reg    <= cfg_data[SPEED_BITS-1:0];
                REG_BLINK:      blink_period_reg <= cfg_data[BLINK_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Round evaluation on the contents of the input register.
    always_comb
    begin
        nearest = dl_reg;
        if (dr_reg < nearest)
            nearest = dr_reg;
        if (db_reg < nearest)
            nearest = db_reg;
    end

    assign dt          = now_reg - last_time_reg;
    assign approaching = last_nearest_reg > nearest;
    assign closing_num = CLOSE_BITS'(last_nearest_reg - nearest) * CLOSE_BITS'(MS_PER_S);
    assign fast_rhs    = PROD_BITS'(fast_speed_reg) * PROD_BITS'(dt);
    assign mod_rhs     = PROD_BITS'(mod_speed_reg) * PROD_BITS'(dt);

    // With no elapsed time the speed cannot be measured, so the flags hold.
    always_comb
    begin
        if (dt == '0)
            closing_next = closing_reg;
        else
        begin
            closing_next.fast     = approaching && (PROD_BITS'(closing_num) > fast_rhs);
            closing_next.moderate = approaching && (PROD_BITS'(closing_num) > mod_rhs);
        end
    end

    pra_side_risk #(.DIST_BITS(DIST_BITS)) u_risk_left (
        .dist_cm(dl_reg), .crit_near(crit_near_reg), .crit_fast(crit_fast_reg),
        .high_near(high_near_reg), .high_mod(high_mod_reg), .warn(warning_reg),
        .closing(closing_next), .risk(rl)
    );

    pra_side_risk #(.DIST_BITS(DIST_BITS)) u_risk_right (
        .dist_cm(dr_reg), .crit_near(crit_near_reg), .crit_fast(crit_fast_reg),
        .high_near(high_near_reg), .high_mod(high_mod_reg), .warn(warning_reg),
        .closing(closing_next), .risk(rr)
    );

    pra_side_risk #(.DIST_BITS(DIST_BITS)) u_risk_back (
        .dist_cm(db_reg), .crit_near(crit_near_reg), .crit_fast(crit_fast_reg),
        .high_near(high_near_reg), .high_mod(high_mod_reg), .warn(warning_reg),
        .closing(closing_next), .risk(rb)
    );

    always_comb
    begin
        lvl = (rr > rl) ? rr : rl;
        if (rb > lvl)
            lvl = rb;
        compact = (rl >= RISK_HIGH) && (rr >= RISK_HIGH) && (rb >= RISK_HIGH);
        // Once anything is high, only the high or critical sides are listed.
        th      = (lvl >= RISK_HIGH) ? RISK_HIGH : RISK_WARNING;
        mask    = {rb >= th, rr >= th, rl >= th};
    end

    assign since_toggle = now_reg - last_toggle_reg;

    always_comb
    begin
        blink_phase_next = blink_phase_reg;
        led_level_next   = led_level_reg;
        last_toggle_next = last_toggle_reg;
        if (lvl == RISK_CRITICAL)
        begin
            if (since_toggle >= TIME_BITS'(blink_period_reg))
            begin
                blink_phase_next = !blink_phase_reg;
                led_level_next   = !blink_phase_reg;
                last_toggle_next = now_reg;
            end
        end
        else
            led_level_next = 1'b0;
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_nearest_reg <= '0;
            last_time_reg    <= '0;
            last_toggle_reg  <= '0;
            closing_reg      <= '0;
            blink_phase_reg  <= 1'b0;
            led_level_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                last_nearest_reg <= nearest;
                last_time_reg    <= now_reg;
                last_toggle_reg  <= last_toggle_next;
                closing_reg      <= closing_next;
                blink_phase_reg  <= blink_phase_next;
                led_level_reg    <= led_level_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            dl_reg  <= s_tdata[DIST_BITS-1:0];
            dr_reg  <= s_tdata[2*DIST_BITS-1:DIST_BITS];
            db_reg  <= s_tdata[3*DIST_BITS-1:2*DIST_BITS];
            now_reg <= s_tdata[3*DIST_BITS+TIME_BITS-1:3*DIST_BITS];
        end
        if (advance)
            out_data_reg <= {led_level_next, lvl, compact, mask, nearest,
                             lvl, rb, rr, rl};
    end

endmodule

[design/pra_side_risk.sv]
// Risk grading of one sensor side from its distance and the closing flags.
// Depends on pra_pkg.
module pra_side_risk #(
    parameter int DIST_BITS = pra_pkg::DIST_BITS_DEF
) (
    input  logic [DIST_BITS-1:0] dist_cm,
    input  logic [DIST_BITS-1:0] crit_near,
    input  logic [DIST_BITS-1:0] crit_fast,
    input  logic [DIST_BITS-1:0] high_near,
    input  logic [DIST_BITS-1:0] high_mod,
    input  logic [DIST_BITS-1:0] warn,
    input  pra_pkg::closing_t    closing,
    output pra_pkg::risk_t       risk
);
    import pra_pkg::*;

    always_comb
    begin
        priority if (dist_cm < crit_near)
            risk = RISK_CRITICAL;
        else if (dist_cm < crit_fast && closing.fast)
            risk = RISK_CRITICAL;
        else if (dist_cm < high_near)
            risk = RISK_HIGH;
        else if (dist_cm < high_mod && closing.moderate)
            risk = RISK_HIGH;
        else if (dist_cm < warn)
            risk = RISK_WARNING;
        else
            risk = RISK_SAFE;
    end

endmodule

[design/pra_checker.sv]
// Port-level checks for proximity_risk_alert, bound to the top level below.
// Depends on pra_pkg.
module pra_checker #(
    parameter int DIST_BITS = pra_pkg::DIST_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((DIST_BITS+15+7)/8)*8-1:0] m_tdata
);
    import pra_pkg::*;

    localparam int ALERT_LSB   = 6;
    localparam int COMPACT_BIT = DIST_BITS + 11;
    localparam int BUZZ_LSB    = DIST_BITS + 12;
    localparam int LED_BIT     = DIST_BITS + 14;

    logic [1:0] rl, rr, rb, alert, buzz, max_risk;

    assign rl       = m_tdata[1:0];
    assign rr       = m_tdata[3:2];
    assign rb       = m_tdata[5:4];
    assign alert    = m_tdata[ALERT_LSB+1:ALERT_LSB];
    assign buzz     = m_tdata[BUZZ_LSB+1:BUZZ_LSB];
    assign max_risk = (rl > rr) ? ((rl > rb) ? rl : rb) : ((rr > rb) ? rr : rb);

    // The overall level is the worst of the three sides.
    a_alert_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> alert == max_risk)
        else $error("alert level differs from the worst side risk");

    // The buzzer pattern follows the alert level.
    a_buzz_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> buzz == alert)
        else $error("buzzer pattern differs from alert level");

    // The LED is only lit while the alert is critical.
    a_led_critical: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[LED_BIT]) |-> alert == RISK_CRITICAL)
        else $error("LED lit outside critical alert");

    // Compact labels need every side at high or critical.
    a_compact_all_high: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[COMPACT_BIT]) |-> (rl[1] && rr[1] && rb[1]))
        else $error("compact labels with a side below high");

    // A stalled result holds its item.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind proximity_risk_alert pra_checker #(.DIST_BITS(DIST_BITS)) u_pra_checker (.*);
